// File: sv/dda_lcr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the line colour rasterizer
package dda_lcr_pkg;

    localparam int COLOR_BITS = 24;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0]
    {
        LANE_X,
        LANE_Y,
        LANE_C
    } lane_t;

    typedef struct packed
    {
        logic  load;
        logic  tick;
        logic  div_start;
        logic  div_capture;
        lane_t lane;
    } dp_cmd_t;

    typedef struct packed
    {
        logic out_full;
        logic n_zero;
        logic div_done;
    } dp_status_t;

endpackage

// File: sv/dda_lcr_in_if.sv
`timescale 1ns / 1ps
// request channel carrying segment loads and ticks
interface dda_lcr_in_if #(parameter int COORD_BITS = 12);
    import dda_lcr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic        [COLOR_BITS-1:0] start_color;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [COLOR_BITS-1:0] end_color;

    modport source
    (
        output valid, operation, start_x, start_y, start_color, end_x, end_y, end_color,
        input  ready
    );

    modport sink
    (
        input  valid, operation, start_x, start_y, start_color, end_x, end_y, end_color,
        output ready
    );
endinterface

// File: sv/dda_lcr_out_if.sv
`timescale 1ns / 1ps
// pixel channel of the line colour rasterizer
interface dda_lcr_out_if #(parameter int COORD_BITS = 12);
    import dda_lcr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic        [COLOR_BITS-1:0] pixel_color;
    logic                         last_pixel;

    modport source
    (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

// File: sv/dda_lcr_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module dda_lcr_div #(
    parameter int NUM_BITS = 41,
    parameter int DEN_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   rem_shift;
    logic [DEN_BITS:0]   rem_sub;
    logic                fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: sv/dda_lcr_ctrl.sv
`timescale 1ns / 1ps
// controller: request handshake and sequencing of the three divisions
module dda_lcr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_operation,
    output logic                    in_ready,
    input  logic                    out_ready,
    input  dda_lcr_pkg::dp_status_t status,
    output dda_lcr_pkg::dp_cmd_t    cmd
);
    import dda_lcr_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    lane_t  lane_reg;
    lane_t  lane_next;
    logic   accept;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && (!status.out_full || out_ready);
        accept     = in_valid && in_ready;
        cmd        = '0;
        cmd.lane   = lane_reg;
        state_next = state_reg;
        lane_next  = lane_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_operation == OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        lane_next  = LANE_X;
                        state_next = ST_LAUNCH;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                    end
                end
            end
            ST_LAUNCH:
            begin
                // zero-length segment: nothing to divide
                if (status.n_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    case (lane_reg)
                        LANE_X:
                        begin
                            lane_next  = LANE_Y;
                            state_next = ST_LAUNCH;
                        end
                        LANE_Y:
                        begin
                            lane_next  = LANE_C;
                            state_next = ST_LAUNCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lane_reg  <= LANE_X;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside the wait state");

    a_load_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_LAUNCH && lane_reg == LANE_X)
        else $error("load did not start the x division");

    a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_capture && lane_reg == LANE_C |=> state_reg == ST_IDLE)
        else $error("colour division did not end the load");
`endif
endmodule

// File: sv/dda_lcr_datapath.sv
`timescale 1ns / 1ps
// datapath: segment setup, increment divider, accumulators and pixel register
module dda_lcr_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  dda_lcr_pkg::dp_cmd_t                      cmd,
    output dda_lcr_pkg::dp_status_t                   status,
    input  logic signed [COORD_BITS-1:0]              start_x,
    input  logic signed [COORD_BITS-1:0]              start_y,
    input  logic        [dda_lcr_pkg::COLOR_BITS-1:0] start_color,
    input  logic signed [COORD_BITS-1:0]              end_x,
    input  logic signed [COORD_BITS-1:0]              end_y,
    input  logic        [dda_lcr_pkg::COLOR_BITS-1:0] end_color,
    input  logic                                      out_ready,
    output logic                                      out_valid,
    output logic signed [COORD_BITS-1:0]              pixel_x,
    output logic signed [COORD_BITS-1:0]              pixel_y,
    output logic        [dda_lcr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                                      last_pixel
);
    import dda_lcr_pkg::*;

    localparam int PW       = COORD_BITS + FRAC_BITS;
    localparam int CW       = COLOR_BITS + FRAC_BITS + 2;
    localparam int NUM_BITS = COLOR_BITS + FRAC_BITS + 1;

    // segment setup
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic signed [COLOR_BITS:0]   dc;
    logic [COORD_BITS-1:0]        dx_mag;
    logic [COORD_BITS-1:0]        dy_mag;
    logic [COLOR_BITS-1:0]        dc_mag;
    logic [COORD_BITS-1:0]        n_steps;

    logic [COORD_BITS-1:0]        dx_mag_reg;
    logic [COORD_BITS-1:0]        dy_mag_reg;
    logic [COLOR_BITS-1:0]        dc_mag_reg;
    logic                         x_neg_reg;
    logic                         y_neg_reg;
    logic                         c_neg_reg;
    logic [COORD_BITS-1:0]        n_reg;

    // accumulators and increments
    logic [PW-1:0]                pos_x_reg;
    logic [PW-1:0]                pos_y_reg;
    logic signed [CW-1:0]         color_reg;
    logic [PW-1:0]                step_x_reg;
    logic [PW-1:0]                step_y_reg;
    logic signed [CW-1:0]         step_c_reg;
    logic [COORD_BITS-1:0]        steps_left_reg;

    logic [PW-1:0]                pos_x_next;
    logic [PW-1:0]                pos_y_next;
    logic signed [CW-1:0]         color_next;
    logic [COLOR_BITS-1:0]        color_sat;
    logic                         emit;

    // division lane
    logic [COLOR_BITS-1:0]        mag_sel;
    logic [NUM_BITS-1:0]          dividend;
    logic [NUM_BITS-1:0]          quotient;
    logic                         div_done;
    logic [PW-1:0]                q_pos;
    logic [CW-1:0]                q_col;

    // output register
    logic                         out_valid_reg;
    logic [COORD_BITS-1:0]        pixel_x_reg;
    logic [COORD_BITS-1:0]        pixel_y_reg;
    logic [COLOR_BITS-1:0]        pixel_color_reg;
    logic                         last_reg;

    always_comb
    begin
        dx      = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy      = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        dc      = {1'b0, end_color} - {1'b0, start_color};
        dx_mag  = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        dy_mag  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        dc_mag  = dc[COLOR_BITS] ? COLOR_BITS'(-dc) : dc[COLOR_BITS-1:0];
        n_steps = (dx_mag > dy_mag) ? dx_mag : dy_mag;
    end

    // rounded division: (mag * 2^FRAC_BITS + n/2) / n
    always_comb
    begin
        case (cmd.lane)
            LANE_X:  mag_sel = {{(COLOR_BITS-COORD_BITS){1'b0}}, dx_mag_reg};
            LANE_Y:  mag_sel = {{(COLOR_BITS-COORD_BITS){1'b0}}, dy_mag_reg};
            default: mag_sel = dc_mag_reg;
        endcase
        dividend = {1'b0, mag_sel, {FRAC_BITS{1'b0}}} + NUM_BITS'(n_reg[COORD_BITS-1:1]);
        q_pos    = PW'(quotient);
        q_col    = {1'b0, quotient};
    end

    dda_lcr_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (COORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        emit       = cmd.tick && (steps_left_reg != '0);
        pos_x_next = pos_x_reg + step_x_reg;
        pos_y_next = pos_y_reg + step_y_reg;
        color_next = color_reg + step_c_reg;
        if (color_next[CW-1])
        begin
            color_sat = '0;
        end
        else if (color_next[CW-2])
        begin
            color_sat = '1;
        end
        else
        begin
            color_sat = color_next[FRAC_BITS +: COLOR_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                steps_left_reg <= n_steps;
            end
            else if (emit)
            begin
                steps_left_reg <= steps_left_reg - 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_mag_reg <= dx_mag;
            dy_mag_reg <= dy_mag;
            dc_mag_reg <= dc_mag;
            x_neg_reg  <= dx[COORD_BITS];
            y_neg_reg  <= dy[COORD_BITS];
            c_neg_reg  <= dc[COLOR_BITS];
            n_reg      <= n_steps;
            // start value plus half an lsb so the floor rounds to nearest
            pos_x_reg  <= {start_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
            pos_y_reg  <= {start_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
            color_reg  <= {2'b00, start_color, 1'b1, {(FRAC_BITS-1){1'b0}}};
        end
        else if (emit)
        begin
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            color_reg       <= color_next;
            pixel_x_reg     <= pos_x_next[PW-1:FRAC_BITS];
            pixel_y_reg     <= pos_y_next[PW-1:FRAC_BITS];
            pixel_color_reg <= color_sat;
            last_reg        <= (steps_left_reg == COORD_BITS'(1));
        end

        if (cmd.div_capture)
        begin
            case (cmd.lane)
                LANE_X:  step_x_reg <= x_neg_reg ? -q_pos : q_pos;
                LANE_Y:  step_y_reg <= y_neg_reg ? -q_pos : q_pos;
                default: step_c_reg <= c_neg_reg ? -q_col : q_col;
            endcase
        end
    end

    always_comb
    begin
        status.out_full = out_valid_reg;
        status.n_zero   = (n_reg == '0);
        status.div_done = div_done;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_reg;

`ifndef SYNTH
    a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick && steps_left_reg == COORD_BITS'(1)
        |=> out_valid_reg && last_reg && steps_left_reg == '0)
        else $error("final step did not flag the last pixel");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick && steps_left_reg == '0 |=> !out_valid_reg)
        else $error("tick without an active segment produced a pixel");
`endif
endmodule

// File: sv/dda_line_color_rasterizer.sv
`timescale 1ns / 1ps
// top level of the dda line rasterizer with colour interpolation
// tick: one request per cycle unless the pixel output stalls; the pixel is held in the
// output register from the cycle after the tick; load: busy while the bit-serial divider
// runs three times (x, y, colour increments); a zero-length segment skips the divisions
// reset: asynchronous, active low; clears the step count so no segment is active
module dda_line_color_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input logic           clk,
    input logic           rst_n,
    dda_lcr_in_if.sink    seg,
    dda_lcr_out_if.source pix
);
    import dda_lcr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dda_lcr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (seg.valid),
        .in_operation (seg.operation),
        .in_ready     (seg.ready),
        .out_ready    (pix.ready),
        .status       (status),
        .cmd          (cmd)
    );

    dda_lcr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (seg.start_x),
        .start_y     (seg.start_y),
        .start_color (seg.start_color),
        .end_x       (seg.end_x),
        .end_y       (seg.end_y),
        .end_color   (seg.end_color),
        .out_ready   (pix.ready),
        .out_valid   (pix.valid),
        .pixel_x     (pix.pixel_x),
        .pixel_y     (pix.pixel_y),
        .pixel_color (pix.pixel_color),
        .last_pixel  (pix.last_pixel)
    );
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the dda line rasterizer with colour interpolation
module testbench;
    import dda_lcr_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int FRAC_BITS       = 16;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 600;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int HOLD_OFF_STEPS  = 300;
    localparam int SETTLE_CYCLES   = 160;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int COLOR_MAX       = (1 << COLOR_BITS) - 1;

    typedef logic signed [COORD_BITS-1:0]           coord_t;
    typedef logic        [COLOR_BITS-1:0]           color_t;
    typedef logic signed [COORD_BITS+FRAC_BITS-1:0] coord_acc_t;
    typedef logic signed [COLOR_BITS+FRAC_BITS:0]   color_acc_t;
    typedef logic        [COORD_BITS:0]             count_t;

    localparam logic [FRAC_BITS-1:0] HALF_FRAC = {1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef struct packed
    {
        logic   operation;
        coord_t start_x;
        coord_t start_y;
        color_t start_color;
        coord_t end_x;
        coord_t end_y;
        color_t end_color;
    } seg_req_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } pixel_t;

    // how a directed row is checked: by the predictor, no pixel at all, or a typed pixel
    typedef enum
    {
        ROW_MODEL,
        ROW_NONE,
        ROW_PIXEL
    } row_kind_t;

    typedef struct
    {
        row_kind_t kind;
        seg_req_t  req;
        pixel_t    want;
    } dir_row_t;

    localparam seg_req_t TICK_REQ = '{operation: OP_TICK, default: '0};

    dir_row_t directed_rows [24] = '{
        '{ROW_NONE,  TICK_REQ, '0},
        // zero-length segment
        '{ROW_NONE,  '{OP_LOAD, 12'sd5, -12'sd7, 24'h123456, 12'sd5, -12'sd7, 24'hABCDEF}, '0},
        '{ROW_NONE,  TICK_REQ, '0},
        '{ROW_NONE,  '{OP_LOAD, 12'sd0, 12'sd0, 24'h000000, 12'sd1, 12'sd0, 24'hFFFFFF}, '0},
        '{ROW_PIXEL, TICK_REQ, '{12'sd1, 12'sd0, 24'hFFFFFF, 1'b1}},
        '{ROW_NONE,  TICK_REQ, '0},
        '{ROW_NONE,  '{OP_LOAD, 12'sd2047, 12'sd2047, 24'hFFFFFF,
                       12'sd2046, 12'sd2046, 24'h000000}, '0},
        '{ROW_PIXEL, TICK_REQ, '{12'sd2046, 12'sd2046, 24'h000000, 1'b1}},
        '{ROW_NONE,  '{OP_LOAD, 12'sh800, 12'sh800, 24'h000000,
                       -12'sd2047, 12'sh800, 24'h800000}, '0},
        '{ROW_PIXEL, TICK_REQ, '{-12'sd2047, 12'sh800, 24'h800000, 1'b1}},
        // steep segment, colour falling
        '{ROW_NONE,  '{OP_LOAD, 12'sd3, 12'sd3, 24'h000010, 12'sd4, 12'sd5, 24'h000000}, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_PIXEL, TICK_REQ, '{12'sd4, 12'sd5, 24'h000000, 1'b1}},
        // full-screen diagonals, each cut short by the next load
        '{ROW_NONE,  '{OP_LOAD, 12'sh800, 12'sh800, 24'h000000,
                       12'sd2047, 12'sd2047, 24'hFFFFFF}, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_NONE,  '{OP_LOAD, 12'sd2047, 12'sh800, 24'hFFFFFF,
                       12'sh800, 12'sd2047, 24'h000000}, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_NONE,  '{OP_LOAD, 12'sd10, 12'sd10, 24'h00FF00, 12'sd8, 12'sd11, 24'h0000FF}, '0},
        '{ROW_MODEL, TICK_REQ, '0},
        '{ROW_PIXEL, TICK_REQ, '{12'sd8, 12'sd11, 24'h0000FF, 1'b1}},
        '{ROW_NONE,  TICK_REQ, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    dda_lcr_in_if  #(.COORD_BITS(COORD_BITS)) seg_bus ();
    dda_lcr_out_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    dda_line_color_rasterizer #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .seg  (seg_bus),
        .pix  (pix_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // line state of the predictor
    coord_acc_t pen_x       = '0;
    coord_acc_t pen_y       = '0;
    color_acc_t pen_color   = '0;
    coord_acc_t inc_x       = '0;
    coord_acc_t inc_y       = '0;
    color_acc_t inc_color   = '0;
    count_t     pixels_left = '0;

    pixel_t pixel_queue [$];

    int  error_count    = 0;
    int  pixels_checked = 0;
    int  loads_sent     = 0;
    int  idle_ticks     = 0;
    int  work_items     = 0;
    int  burst_left     = 0;
    int  cycle_count    = 0;
    bit  no_gaps        = 1'b0;
    bit  hold_off_req   = 1'b0;
    bit  hold_off_done  = 1'b0;

    // difference over step count in fixed point, rounded half away from zero
    function automatic longint fx_increment(input longint diff, input longint steps);
        longint mag;
        longint q;
        mag = (diff < 0 ? -diff : diff) * (longint'(1) << FRAC_BITS);
        q   = (mag + steps / 2) / steps;
        return diff < 0 ? -q : q;
    endfunction

    function automatic bit line_step(input seg_req_t req, output pixel_t px);
        longint     dx;
        longint     dy;
        longint     ady;
        longint     span;
        color_acc_t shade;
        px = '0;
        if (req.operation == OP_LOAD)
        begin
            dx   = longint'(req.end_x) - longint'(req.start_x);
            dy   = longint'(req.end_y) - longint'(req.start_y);
            span = dx < 0 ? -dx : dx;
            ady  = dy < 0 ? -dy : dy;
            if (ady > span)
                span = ady;
            // start plus half a pixel so the floor rounds to nearest
            pen_x       = {req.start_x, HALF_FRAC};
            pen_y       = {req.start_y, HALF_FRAC};
            pen_color   = {1'b0, req.start_color, HALF_FRAC};
            pixels_left = count_t'(span);
            if (span > 0)
            begin
                inc_x     = coord_acc_t'(fx_increment(dx, span));
                inc_y     = coord_acc_t'(fx_increment(dy, span));
                inc_color = color_acc_t'(fx_increment(
                    longint'(req.end_color) - longint'(req.start_color), span));
            end
            else
            begin
                inc_x     = '0;
                inc_y     = '0;
                inc_color = '0;
            end
            return 1'b0;
        end
        if (pixels_left == 0)
            return 1'b0;
        pen_x       += inc_x;
        pen_y       += inc_y;
        pen_color   += inc_color;
        pixels_left -= 1'b1;
        shade = pen_color >>> FRAC_BITS;
        px.pixel_x = pen_x[FRAC_BITS +: COORD_BITS];
        px.pixel_y = pen_y[FRAC_BITS +: COORD_BITS];
        if (shade < 0)
            px.pixel_color = '0;
        else if (shade > color_acc_t'(COLOR_MAX))
            px.pixel_color = '1;
        else
            px.pixel_color = shade[COLOR_BITS-1:0];
        px.last_pixel = (pixels_left == 0);
        return 1'b1;
    endfunction

    function automatic seg_req_t random_request(input logic op);
        seg_req_t req;
        req.operation   = op;
        req.start_x     = coord_t'($urandom);
        req.start_y     = coord_t'($urandom);
        req.start_color = color_t'($urandom);
        req.end_x       = coord_t'($urandom);
        req.end_y       = coord_t'($urandom);
        req.end_color   = color_t'($urandom);
        return req;
    endfunction

    function automatic coord_t coord_near(input coord_t base, input int reach);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < -(1 << (COORD_BITS - 1)))
            v = -(1 << (COORD_BITS - 1));
        if (v > (1 << (COORD_BITS - 1)) - 1)
            v = (1 << (COORD_BITS - 1)) - 1;
        return coord_t'(v);
    endfunction

    task automatic send_request(input seg_req_t req, input row_kind_t kind, input pixel_t want);
        pixel_t px;
        int     gap;
        bit     emits;
        if (burst_left == 0)
        begin
            gap        = no_gaps ? 0 : $urandom_range(0, 7);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                seg_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        seg_bus.valid       <= 1'b1;
        seg_bus.operation   <= req.operation;
        seg_bus.start_x     <= req.start_x;
        seg_bus.start_y     <= req.start_y;
        seg_bus.start_color <= req.start_color;
        seg_bus.end_x       <= req.end_x;
        seg_bus.end_y       <= req.end_y;
        seg_bus.end_color   <= req.end_color;
        @(posedge clk);
        while (!seg_bus.ready)
            @(posedge clk);
        emits = line_step(req, px);
        if (kind == ROW_PIXEL)
            pixel_queue.push_back(want);
        else if (kind == ROW_MODEL && emits)
            pixel_queue.push_back(px);
        if (req.operation == OP_LOAD)
        begin
            loads_sent++;
            work_items++;
        end
        else if (emits)
            work_items++;
        else
            idle_ticks++;
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (pixel_queue.size() == 0)
            begin
                $error("pixel with no tick waiting: x=%0d y=%0d colour=%h",
                       pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color);
                error_count++;
            end
            else
            begin
                want = pixel_queue.pop_front();
                pixels_checked++;
                if (pix_bus.pixel_x !== want.pixel_x)
                begin
                    $error("pixel_x: expected %0d, actual %0d", want.pixel_x, pix_bus.pixel_x);
                    error_count++;
                end
                if (pix_bus.pixel_y !== want.pixel_y)
                begin
                    $error("pixel_y: expected %0d, actual %0d", want.pixel_y, pix_bus.pixel_y);
                    error_count++;
                end
                if (pix_bus.pixel_color !== want.pixel_color)
                begin
                    $error("pixel_color: expected %h, actual %h",
                           want.pixel_color, pix_bus.pixel_color);
                    error_count++;
                end
                if (pix_bus.last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel: expected %0b, actual %0b",
                           want.last_pixel, pix_bus.last_pixel);
                    error_count++;
                end
            end
        end
    end

    // pixel receiver: stall pattern changes from span to span
    initial
    begin
        int mode;
        int span;
        int phase;
        phase = 0;
        pix_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                pix_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 160);
            for (int i = 0; i < span && !(hold_off_req && !hold_off_done); i++)
            begin
                case (mode)
                    0:       pix_bus.ready <= 1'b1;
                    1:       pix_bus.ready <= $urandom_range(0, 1);
                    2:       pix_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: pix_bus.ready <= (phase % 5) != 0;
                endcase
                @(posedge clk);
                phase++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("no progress after %0d cycles", CYCLE_LIMIT);
        $display("** dda_line_color_rasterizer: FAILED **");
        $finish;
    end

    initial
    begin
        seg_req_t req;
        int       pick;
        int       ticks;
        int       drain;
        rst_n               <= 1'b0;
        seg_bus.valid       <= 1'b0;
        seg_bus.operation   <= OP_TICK;
        seg_bus.start_x     <= '0;
        seg_bus.start_y     <= '0;
        seg_bus.start_color <= '0;
        seg_bus.end_x       <= '0;
        seg_bus.end_y       <= '0;
        seg_bus.end_color   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].want);
        work_items = 0;

        // long segment ticked back to back while the receiver holds off
        no_gaps      = 1'b1;
        hold_off_req = 1'b1;
        req = '{OP_LOAD, -12'sd1000, -12'sd20, 24'h000000, -12'sd700, 12'sd40, 24'hFFFFFF};
        send_request(req, ROW_MODEL, '0);
        repeat (HOLD_OFF_STEPS) send_request(random_request(OP_TICK), ROW_MODEL, '0);
        no_gaps = 1'b0;

        while (work_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_request(random_request(OP_TICK), ROW_MODEL, '0);
                continue;
            end
            req = random_request(OP_LOAD);
            if ($urandom_range(0, 7) == 0)
                req.start_color = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 7) == 0)
                req.end_color = $urandom_range(0, 1) ? '1 : '0;
            if (pick < 12)
            begin
                req.end_x = req.start_x;
                req.end_y = req.start_y;
            end
            else if (pick < 70)
            begin
                req.end_x = coord_near(req.start_x, 16);
                req.end_y = coord_near(req.start_y, 16);
            end
            else if (pick < 85)
            begin
                req.end_x = coord_near(req.start_x, 80);
                req.end_y = coord_near(req.start_y, 80);
            end
            send_request(req, ROW_MODEL, '0);
            // long random segments are abandoned part way by the next load
            if (pick >= 85)
                ticks = $urandom_range(0, 24);
            else if ($urandom_range(0, 9) == 0)
                ticks = $urandom_range(0, int'(pixels_left));
            else
                ticks = int'(pixels_left) + $urandom_range(0, 2);
            repeat (ticks) send_request(random_request(OP_TICK), ROW_MODEL, '0);
        end
        seg_bus.valid <= 1'b0;

        drain = 0;
        while (pixel_queue.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixel_queue.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pixel_queue.size());
            error_count++;
        end

        $display("checked %0d pixels from %0d segment loads; %0d ticks found no segment",
                 pixels_checked, loads_sent, idle_ticks);
        $display("pixel output held off for %0d cycles while ticks kept coming",
                 HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("** dda_line_color_rasterizer: PASSED **");
        else
            $display("** dda_line_color_rasterizer: FAILED **");
        $finish;
    end

endmodule
